// ===== hw/rtl/alarm_panel_controller_defines.svh =====
// assertion macros for the alarm panel controller
// included by files that carry concurrent checks, no other dependencies
`ifndef ALARM_PANEL_CONTROLLER_DEFINES_SVH
`define ALARM_PANEL_CONTROLLER_DEFINES_SVH

// same-cycle implication, disabled while reset is asserted
`define APC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("apc check failed: same-cycle implication");

// next-cycle implication, disabled while reset is asserted
`define APC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("apc check failed: next-cycle implication");

`endif

// ===== hw/rtl/apc_pkg.sv =====
// shared types and constants for the alarm panel controller
// no dependencies
package apc_pkg;

  // default tick periods
  localparam int unsigned MODE_PERIOD_DEF    = 2;
  localparam int unsigned LED_PERIOD_DEF     = 5;
  localparam int unsigned SLOW_BLINK_DIV_DEF = 5;

  // field widths
  localparam int unsigned KEY_W  = 8;
  localparam int unsigned TEMP_W = 9;
  localparam int unsigned CFG_IDX_W = 2;

  // word widths, padded to whole bytes
  localparam int unsigned IN_DATA_W  = 24;
  localparam int unsigned OUT_DATA_W = 8;

  // keypad codes
  localparam logic [KEY_W-1:0] KEY_A = 8'h11;
  localparam logic [KEY_W-1:0] KEY_B = 8'h12;
  localparam logic [KEY_W-1:0] KEY_D = 8'h14;

  // limit register reset values
  localparam logic signed [TEMP_W-1:0] C_LOW_RST  = 9'sd0;
  localparam logic signed [TEMP_W-1:0] C_HIGH_RST = 9'sd40;
  localparam logic signed [TEMP_W-1:0] F_LOW_RST  = 9'sd32;
  localparam logic signed [TEMP_W-1:0] F_HIGH_RST = 9'sd104;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_C_LOW  = 2'd0,
    CFG_C_HIGH = 2'd1,
    CFG_F_LOW  = 2'd2,
    CFG_F_HIGH = 2'd3
  } apc_cfg_idx_e;

  typedef enum logic [1:0] {
    MODE_DISARMED = 2'd0,
    MODE_ARMED    = 2'd1,
    MODE_ALARM    = 2'd2
  } apc_mode_e;

  typedef struct packed {
    logic signed [TEMP_W-1:0] c_low;
    logic signed [TEMP_W-1:0] c_high;
    logic signed [TEMP_W-1:0] f_low;
    logic signed [TEMP_W-1:0] f_high;
  } apc_limits_t;

  typedef struct packed {
    logic [KEY_W-1:0]         key_code;
    logic                     touch_one;
    logic                     touch_two;
    logic                     sample_valid;
    logic signed [TEMP_W-1:0] temperature;
  } apc_item_t;

  typedef struct packed {
    apc_mode_e mode;
    logic      tone_enable;
    logic      temp_alarm;
    logic      unit_fahrenheit;
  } apc_mode_status_t;

  typedef struct packed {
    logic led_a;
    logic led_b;
  } apc_led_status_t;

endpackage

// ===== hw/rtl/apc_cfg.sv =====
// temperature limit registers written through the configuration channel
// depends on apc_pkg
module apc_cfg (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_valid_i,
  input  logic [apc_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [apc_pkg::TEMP_W-1:0]      cfg_data_i,
  output apc_pkg::apc_limits_t            limits_o
);
  import apc_pkg::*;

  apc_limits_t limits_q, limits_d;

  always_comb begin
    limits_d = limits_q;
    if (cfg_valid_i) begin
      case (apc_cfg_idx_e'(cfg_index_i))
        CFG_C_LOW:  limits_d.c_low  = $signed(cfg_data_i);
        CFG_C_HIGH: limits_d.c_high = $signed(cfg_data_i);
        CFG_F_LOW:  limits_d.f_low  = $signed(cfg_data_i);
        CFG_F_HIGH: limits_d.f_high = $signed(cfg_data_i);
        default:    limits_d = limits_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limits_q.c_low  <= C_LOW_RST;
      limits_q.c_high <= C_HIGH_RST;
      limits_q.f_low  <= F_LOW_RST;
      limits_q.f_high <= F_HIGH_RST;
    end else begin
      limits_q <= limits_d;
    end
  end

  assign limits_o = limits_q;

endmodule

// ===== hw/rtl/apc_mode.sv =====
// mode state machine, unit select, tone and temperature range flag
// depends on apc_pkg
module apc_mode #(
  parameter int unsigned MODE_PERIOD = apc_pkg::MODE_PERIOD_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     step_i,
  input  apc_pkg::apc_item_t       item_i,
  input  apc_pkg::apc_limits_t     limits_i,
  output apc_pkg::apc_mode_status_t status_o
);
  import apc_pkg::*;

  localparam int unsigned PW = (MODE_PERIOD > 1) ? $clog2(MODE_PERIOD) : 1;
  localparam logic [PW-1:0] PHASE_LAST = PW'(MODE_PERIOD - 1);

  logic [PW-1:0]             phase_q, phase_d;
  apc_mode_e                 mode_q, mode_d;
  logic                      unit_q, unit_d;
  logic                      tone_q, tone_d;
  logic                      temp_flag_q, temp_flag_d;
  logic                      run;
  logic signed [TEMP_W-1:0]  lo, hi;

  assign run = (phase_q >= PHASE_LAST);

  always_comb begin
    phase_d     = run ? '0 : phase_q + PW'(1);
    mode_d      = mode_q;
    unit_d      = unit_q;
    tone_d      = tone_q;
    temp_flag_d = temp_flag_q;
    if (run) begin
      if (item_i.key_code == KEY_B) begin
        unit_d = ~unit_q;
      end
      case (mode_q)
        MODE_DISARMED: begin
          tone_d = 1'b0;
          if (item_i.key_code == KEY_A) mode_d = MODE_ARMED;
        end
        MODE_ARMED: begin
          tone_d = 1'b0;
          // flag from before this tick's sample
          if (item_i.touch_one || item_i.touch_two || temp_flag_q) mode_d = MODE_ALARM;
          if (item_i.key_code == KEY_D) mode_d = MODE_DISARMED;
        end
        MODE_ALARM: begin
          tone_d = 1'b1;
          if (item_i.key_code == KEY_D) mode_d = MODE_DISARMED;
        end
        default: mode_d = mode_q;
      endcase
    end
    // limits of the unit after this tick's key
    lo = unit_d ? limits_i.f_low  : limits_i.c_low;
    hi = unit_d ? limits_i.f_high : limits_i.c_high;
    if (item_i.sample_valid) begin
      temp_flag_d = ($signed(item_i.temperature) < lo) ||
                    ($signed(item_i.temperature) > hi);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PHASE_LAST;
      mode_q      <= MODE_ARMED;
      unit_q      <= 1'b0;
      tone_q      <= 1'b0;
      temp_flag_q <= 1'b0;
    end else if (step_i) begin
      phase_q     <= phase_d;
      mode_q      <= mode_d;
      unit_q      <= unit_d;
      tone_q      <= tone_d;
      temp_flag_q <= temp_flag_d;
    end
  end

  assign status_o.mode            = mode_d;
  assign status_o.tone_enable     = tone_d;
  assign status_o.temp_alarm      = temp_flag_d;
  assign status_o.unit_fahrenheit = unit_d;

endmodule

// ===== hw/rtl/apc_led.sv =====
// pad led pattern logic: touch flashing, armed alternation, latched alarm flashing
// depends on apc_pkg
module apc_led #(
  parameter int unsigned LED_PERIOD     = apc_pkg::LED_PERIOD_DEF,
  parameter int unsigned SLOW_BLINK_DIV = apc_pkg::SLOW_BLINK_DIV_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     step_i,
  input  apc_pkg::apc_mode_e       mode_i,
  input  logic                     touch_one_i,
  input  logic                     touch_two_i,
  output apc_pkg::apc_led_status_t leds_o
);
  import apc_pkg::*;

  localparam int unsigned PW = (LED_PERIOD > 1) ? $clog2(LED_PERIOD) : 1;
  localparam logic [PW-1:0] PHASE_LAST = PW'(LED_PERIOD - 1);
  localparam logic [7:0]    DIV_LIMIT  = 8'(SLOW_BLINK_DIV);

  logic [PW-1:0] phase_q, phase_d;
  logic [7:0]    div_q, div_d;
  logic          blink_q, blink_d;
  logic [1:0]    latch_q, latch_d;
  logic          led_a_q, led_a_d;
  logic          led_b_q, led_b_d;
  logic          run;

  assign run = (phase_q >= PHASE_LAST);

  always_comb begin
    phase_d = run ? '0 : phase_q + PW'(1);
    div_d   = div_q;
    blink_d = blink_q;
    latch_d = latch_q;
    led_a_d = led_a_q;
    led_b_d = led_b_q;
    if (run) begin
      case (mode_i)
        MODE_ALARM: begin
          // touch one latches bit 1, touch two bit 0
          latch_d = latch_q | {touch_one_i, touch_two_i};
          if (!touch_one_i) led_b_d = 1'b0;
          if (!touch_two_i) led_a_d = 1'b0;
          if (latch_d != 2'b00) begin
            blink_d = ~blink_q;
            if (latch_d[0]) led_b_d = ~blink_q;
            if (latch_d[1]) led_a_d = ~blink_q;
          end
        end
        MODE_DISARMED: begin
          latch_d = 2'b00;
          if (div_q >= DIV_LIMIT) begin
            div_d   = 8'd0;
            led_a_d = touch_one_i & ~led_a_q;
            led_b_d = touch_two_i & ~led_b_q;
          end
        end
        MODE_ARMED: begin
          latch_d = 2'b00;
          if (div_q >= DIV_LIMIT) begin
            div_d   = 8'd0;
            blink_d = ~blink_q;
            led_a_d = ~blink_q;
            led_b_d = blink_q;
          end
        end
        default: latch_d = latch_q;
      endcase
      div_d = div_d + 8'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PHASE_LAST;
      div_q   <= DIV_LIMIT;
      blink_q <= 1'b0;
      latch_q <= 2'b00;
      led_a_q <= 1'b0;
      led_b_q <= 1'b0;
    end else if (step_i) begin
      phase_q <= phase_d;
      div_q   <= div_d;
      blink_q <= blink_d;
      latch_q <= latch_d;
      led_a_q <= led_a_d;
      led_b_q <= led_b_d;
    end
  end

  assign leds_o.led_a = led_a_d;
  assign leds_o.led_b = led_b_d;

endmodule

// ===== hw/rtl/alarm_panel_controller.sv =====
// alarm panel controller top level: input register, step logic, result register
// depends on apc_pkg, apc_cfg, apc_mode, apc_led and alarm_panel_controller_defines.svh
//
// usage
// - s_axis carries one 10 ms tick per word: keypad code, two touch flags and an
//   optional temperature sample; m_axis returns one status word per tick
// - the configuration channel writes the four temperature limits by index
//   (celsius low/high, fahrenheit low/high); it is always ready and must only be
//   used while no tick is in flight
// - a tick word is captured in an input register, the mode, range and led logic
//   run in one pass behind it and the status lands in a result register, which
//   drives m_axis_tvalid and m_axis_tdata
// - throughput is one word per cycle; both sides may stall freely
// - when the receiver stalls, the result register holds its word and the input
//   register may still take one more word; s_axis_tready then drops until the
//   receiver takes the pending status
// - reset clears both registers to empty, loads the limits with their defaults,
//   sets the mode to armed and arranges for mode and led logic to run on the
//   first tick
`include "alarm_panel_controller_defines.svh"

module alarm_panel_controller #(
  parameter int unsigned MODE_PERIOD    = apc_pkg::MODE_PERIOD_DEF,
  parameter int unsigned LED_PERIOD     = apc_pkg::LED_PERIOD_DEF,
  parameter int unsigned SLOW_BLINK_DIV = apc_pkg::SLOW_BLINK_DIV_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // tick input
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // [7:0] key_code, [8] touch_one, [9] touch_two, [10] sample_valid,
  // [19:11] temperature, [23:20] zero
  input  logic [apc_pkg::IN_DATA_W-1:0]   s_axis_tdata,
  // status output
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // [1:0] mode, [2] tone_enable, [3] temp_alarm, [4] unit_fahrenheit,
  // [5] led_a, [6] led_b, [7] zero
  output logic [apc_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
  // limit register writes
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [apc_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [apc_pkg::TEMP_W-1:0]      cfg_data_i
);
  import apc_pkg::*;

  // input register
  logic              in_valid_q, in_valid_d;
  apc_item_t         in_item_q;
  // result register
  logic              out_valid_q, out_valid_d;
  logic [OUT_DATA_W-1:0] out_data_q;

  logic              advance;
  logic              in_take;
  apc_limits_t       limits;
  apc_mode_status_t  mode_status;
  apc_led_status_t   led_status;

  // the buffered word moves on when the result register is empty or being emptied
  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;
  assign in_take       = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o   = 1'b1;

  assign in_valid_d  = in_take ? 1'b1 : (advance ? 1'b0 : in_valid_q);
  assign out_valid_d = advance ? 1'b1 : (m_axis_tready ? 1'b0 : out_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_item_q.key_code     <= s_axis_tdata[7:0];
      in_item_q.touch_one    <= s_axis_tdata[8];
      in_item_q.touch_two    <= s_axis_tdata[9];
      in_item_q.sample_valid <= s_axis_tdata[10];
      in_item_q.temperature  <= $signed(s_axis_tdata[19:11]);
    end
    if (advance) begin
      out_data_q <= {1'b0, led_status.led_b, led_status.led_a,
                     mode_status.unit_fahrenheit, mode_status.temp_alarm,
                     mode_status.tone_enable, mode_status.mode};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  apc_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .limits_o    (limits)
  );

  apc_mode #(
    .MODE_PERIOD (MODE_PERIOD)
  ) u_mode (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (advance),
    .item_i   (in_item_q),
    .limits_i (limits),
    .status_o (mode_status)
  );

  // led logic sees the mode as it stands after this tick's mode logic
  apc_led #(
    .LED_PERIOD     (LED_PERIOD),
    .SLOW_BLINK_DIV (SLOW_BLINK_DIV)
  ) u_led (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (advance),
    .mode_i      (mode_status.mode),
    .touch_one_i (in_item_q.touch_one),
    .touch_two_i (in_item_q.touch_two),
    .leds_o      (led_status)
  );

  // a buffered word that cannot move on must still be there next cycle
  `APC_ASSERT_NEXT(a_hold_pending, clk_i, rst_ni, in_valid_q && !advance, in_valid_q)
  // a new word is only taken when the input register is free or draining
  `APC_ASSERT_NOW(a_no_overwrite, clk_i, rst_ni, s_axis_tvalid && s_axis_tready, !in_valid_q || advance)
  // the result register is only loaded when empty or being taken
  `APC_ASSERT_NOW(a_no_result_loss, clk_i, rst_ni, advance, !out_valid_q || m_axis_tready)

endmodule

// ===== tb/tb.sv =====
// self-checking bench for alarm_panel_controller: tick words in, status words out
// depends on apc_pkg and the alarm_panel_controller rtl only
`timescale 1ns / 1ps

module tb;
  import apc_pkg::*;

  localparam logic [KEY_W-1:0] KEY_C    = 8'h13;
  localparam logic [KEY_W-1:0] KEY_NONE = 8'h00;
  localparam int unsigned LONG_HOLD   = 40;
  localparam int unsigned CYCLE_LIMIT = 200_000;
  localparam int unsigned RANDOM_TICKS = 180;

  // expected status of one tick, in the order of the output word fields
  typedef struct packed {
    apc_mode_e mode;
    logic      tone_enable;
    logic      temp_alarm;
    logic      unit_fahrenheit;
    logic      led_a;
    logic      led_b;
  } panel_status_t;

  // one directed tick; pinned rows carry a hand-written status
  typedef struct packed {
    apc_item_t     item;
    logic          pinned;
    panel_status_t status;
  } tick_row_t;

  localparam panel_status_t UNPINNED = '{MODE_DISARMED, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0};

  // mode logic runs on odd rows (first tick after reset), led logic on rows 1, 6, 11, ...
  localparam tick_row_t DIRECTED [22] = '{
    // first tick: armed pattern starts with the first led lit
    '{'{KEY_NONE, 1'b0, 1'b0, 1'b0, 9'sd0}, 1'b1,
      '{MODE_ARMED, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0}},
    // disarm key between mode ticks is ignored
    '{'{KEY_D, 1'b0, 1'b0, 1'b0, 9'sd0}, 1'b1,
      '{MODE_ARMED, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0}},
    // unit toggles to fahrenheit, sample on the high limit is in range
    '{'{KEY_B, 1'b0, 1'b0, 1'b1, 9'sd104}, 1'b1,
      '{MODE_ARMED, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0}},
    // one above the high limit
    '{'{KEY_NONE, 1'b0, 1'b0, 1'b1, 9'sd105}, 1'b1,
      '{MODE_ARMED, 1'b0, 1'b1, 1'b1, 1'b1, 1'b0}},
    // lagged temperature flag trips the alarm, key c does nothing, tone not yet on
    '{'{KEY_C, 1'b0, 1'b0, 1'b0, 9'sd0}, 1'b1,
      '{MODE_ALARM, 1'b0, 1'b1, 1'b1, 1'b1, 1'b0}},
    '{'{KEY_NONE, 1'b1, 1'b0, 1'b1, 9'sd32}, 1'b0, UNPINNED},
    '{'{KEY_NONE, 1'b0, 1'b1, 1'b0, 9'sd0}, 1'b0, UNPINNED},
    '{'{KEY_NONE, 1'b1, 1'b1, 1'b1, 9'sd31}, 1'b0, UNPINNED},
    '{'{KEY_D, 1'b1, 1'b0, 1'b0, 9'sd0}, 1'b0, UNPINNED},
    '{'{KEY_A, 1'b0, 1'b0, 1'b0, 9'sd0}, 1'b0, UNPINNED},
    '{'{KEY_A, 1'b0, 1'b0, 1'b0, 9'sd0}, 1'b0, UNPINNED},
    '{'{KEY_NONE, 1'b0, 1'b1, 1'b0, 9'sd0}, 1'b0, UNPINNED},
    // touch and flag while armed, but the disarm key wins
    '{'{KEY_D, 1'b1, 1'b1, 1'b0, 9'sd0}, 1'b0, UNPINNED},
    '{'{8'hff, 1'b1, 1'b1, 1'b1, -9'sd128}, 1'b0, UNPINNED},
    '{'{KEY_B, 1'b0, 1'b0, 1'b1, 9'sd255}, 1'b0, UNPINNED},
    '{'{KEY_NONE, 1'b1, 1'b1, 1'b1, 9'sd0}, 1'b0, UNPINNED},
    '{'{KEY_A, 1'b0, 1'b0, 1'b1, 9'sd40}, 1'b0, UNPINNED},
    '{'{KEY_NONE, 1'b0, 1'b0, 1'b1, 9'sd41}, 1'b0, UNPINNED},
    '{'{KEY_NONE, 1'b0, 1'b0, 1'b0, 9'sd0}, 1'b0, UNPINNED},
    '{'{KEY_NONE, 1'b1, 1'b0, 1'b0, 9'sd0}, 1'b0, UNPINNED},
    '{'{KEY_D, 1'b0, 1'b0, 1'b1, -9'sd1}, 1'b0, UNPINNED},
    '{'{8'hff, 1'b0, 1'b0, 1'b1, 9'sd255}, 1'b0, UNPINNED}
  };

  logic                    clk_i = 1'b0;
  logic                    rst_ni = 1'b0;
  logic                    s_axis_tvalid = 1'b0;
  logic                    s_axis_tready;
  logic [IN_DATA_W-1:0]    s_axis_tdata = '0;
  logic                    m_axis_tvalid;
  logic                    m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0]   m_axis_tdata;
  logic                    cfg_valid_i = 1'b0;
  logic                    cfg_ready_o;
  logic [CFG_IDX_W-1:0]    cfg_index_i = '0;
  logic [TEMP_W-1:0]       cfg_data_i = '0;

  // panel state as the predictor sees it
  apc_mode_e               panel_mode = MODE_ARMED;
  int unsigned             mode_count = MODE_PERIOD_DEF - 1;
  int unsigned             led_count = LED_PERIOD_DEF - 1;
  logic [7:0]              blink_div = 8'(SLOW_BLINK_DIV_DEF);
  logic                    flash = 1'b0;
  logic [1:0]              held_pads = 2'b00;
  logic                    fahrenheit = 1'b0;
  logic                    over_temp = 1'b0;
  logic                    lamp_a = 1'b0;
  logic                    lamp_b = 1'b0;
  logic                    siren = 1'b0;
  logic signed [TEMP_W-1:0] limit_by_reg [4] = '{C_LOW_RST, C_HIGH_RST, F_LOW_RST, F_HIGH_RST};

  panel_status_t           status_due [$];
  int unsigned             faults = 0;
  int unsigned             ticks_sent = 0;
  int unsigned             words_checked = 0;
  int unsigned             limit_writes = 0;
  int unsigned             words_in_mode [3] = '{0, 0, 0};
  int unsigned             cycle_count = 0;
  int unsigned             holds_asked = 0;
  int unsigned             touch_odds = 7;
  bit                      tx_idling = 1'b1;
  bit                      rx_idling = 1'b1;

  always #10 clk_i = ~clk_i;

  alarm_panel_controller i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  // advance the panel by one tick and return the status word it should produce
  function automatic panel_status_t panel_step(apc_item_t it);
    apc_mode_e                was;
    logic signed [TEMP_W-1:0] lo;
    logic signed [TEMP_W-1:0] hi;
    panel_status_t            st;
    // mode logic, every MODE_PERIOD ticks
    if (mode_count >= MODE_PERIOD_DEF - 1) begin
      mode_count = 0;
      was = panel_mode;
      if (it.key_code == KEY_B) fahrenheit = ~fahrenheit;
      // tone follows the mode as it stood when the tick began
      siren = (was == MODE_ALARM);
      case (was)
        MODE_DISARMED: begin
          if (it.key_code == KEY_A) panel_mode = MODE_ARMED;
        end
        MODE_ARMED: begin
          if (it.touch_one || it.touch_two || over_temp) panel_mode = MODE_ALARM;
          if (it.key_code == KEY_D) panel_mode = MODE_DISARMED;
        end
        MODE_ALARM: begin
          if (it.key_code == KEY_D) panel_mode = MODE_DISARMED;
        end
        default: ;
      endcase
    end else begin
      mode_count++;
    end
    // range check against the unit selected after this tick's key
    if (it.sample_valid) begin
      lo = fahrenheit ? limit_by_reg[CFG_F_LOW] : limit_by_reg[CFG_C_LOW];
      hi = fahrenheit ? limit_by_reg[CFG_F_HIGH] : limit_by_reg[CFG_C_HIGH];
      over_temp = ($signed(it.temperature) < lo) || ($signed(it.temperature) > hi);
    end
    // led logic, every LED_PERIOD ticks
    if (led_count >= LED_PERIOD_DEF - 1) begin
      led_count = 0;
      case (panel_mode)
        MODE_ALARM: begin
          // touch one latches the first pad, touch two the second
          if (it.touch_one) held_pads[1] = 1'b1;
          else lamp_b = 1'b0;
          if (it.touch_two) held_pads[0] = 1'b1;
          else lamp_a = 1'b0;
          if (held_pads != 2'b00) begin
            flash = ~flash;
            if (held_pads[0]) lamp_b = flash;
            if (held_pads[1]) lamp_a = flash;
          end
        end
        MODE_DISARMED: begin
          held_pads = 2'b00;
          if (blink_div >= SLOW_BLINK_DIV_DEF) begin
            blink_div = '0;
            lamp_a = it.touch_one ? ~lamp_a : 1'b0;
            lamp_b = it.touch_two ? ~lamp_b : 1'b0;
          end
        end
        MODE_ARMED: begin
          held_pads = 2'b00;
          if (blink_div >= SLOW_BLINK_DIV_DEF) begin
            blink_div = '0;
            flash = ~flash;
            lamp_a = flash;
            lamp_b = ~flash;
          end
        end
        default: ;
      endcase
      blink_div = blink_div + 8'd1;
    end else begin
      led_count++;
    end
    st.mode            = panel_mode;
    st.tone_enable     = siren;
    st.temp_alarm      = over_temp;
    st.unit_fahrenheit = fahrenheit;
    st.led_a           = lamp_a;
    st.led_b           = lamp_b;
    return st;
  endfunction

  // mostly quiet ticks with the odd key, touches, and samples near the live limits or spread over the full range
  function automatic apc_item_t random_tick();
    apc_item_t it;
    int        pick;
    int        degrees;
    pick = $urandom_range(0, 9);
    if (pick < 6) begin
      it.key_code = KEY_NONE;
    end else if (pick < 9) begin
      case ($urandom_range(0, 3))
        0: it.key_code = KEY_A;
        1: it.key_code = KEY_B;
        2: it.key_code = KEY_C;
        default: it.key_code = KEY_D;
      endcase
    end else begin
      it.key_code = 8'($urandom_range(0, 255));
    end
    it.touch_one    = ($urandom_range(0, touch_odds) == 0);
    it.touch_two    = ($urandom_range(0, touch_odds) == 0);
    it.sample_valid = 1'($urandom_range(0, 1));
    if ($urandom_range(0, 1) == 1) begin
      if ($urandom_range(0, 1) == 1)
        degrees = int'(fahrenheit ? limit_by_reg[CFG_F_HIGH] : limit_by_reg[CFG_C_HIGH]);
      else
        degrees = int'(fahrenheit ? limit_by_reg[CFG_F_LOW] : limit_by_reg[CFG_C_LOW]);
      degrees = degrees + int'($urandom_range(0, 2)) - 1;
      if (degrees < -128) degrees = -128;
      if (degrees > 255) degrees = 255;
    end else begin
      degrees = int'($urandom_range(0, 383)) - 128;
    end
    it.temperature = degrees[TEMP_W-1:0];
    return it;
  endfunction

  function automatic logic signed [TEMP_W-1:0] random_limit();
    int degrees;
    degrees = int'($urandom_range(0, 383)) - 128;
    return degrees[TEMP_W-1:0];
  endfunction

  // offer one tick word, optionally after a gap, and log its expected status on accept
  task automatic send_tick(input apc_item_t it, input logic pinned, input panel_status_t given);
    panel_status_t predicted;
    if (tx_idling && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {4'b0000, it.temperature, it.sample_valid, it.touch_two, it.touch_one,
                      it.key_code};
    do @(posedge clk_i); while (!s_axis_tready);
    predicted = panel_step(it);
    status_due.push_back(pinned ? given : predicted);
    ticks_sent++;
  endtask

  // stop offering and let every outstanding status word come back
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (status_due.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_limits(input logic signed [TEMP_W-1:0] c_lo, input logic signed [TEMP_W-1:0] c_hi,
                              input logic signed [TEMP_W-1:0] f_lo, input logic signed [TEMP_W-1:0] f_hi);
    logic signed [TEMP_W-1:0] vals [4];
    vals[CFG_C_LOW]  = c_lo;
    vals[CFG_C_HIGH] = c_hi;
    vals[CFG_F_LOW]  = f_lo;
    vals[CFG_F_HIGH] = f_hi;
    for (int r = 0; r < 4; r++) begin
      cfg_valid_i <= 1'b1;
      cfg_index_i <= r[CFG_IDX_W-1:0];
      cfg_data_i  <= vals[r];
      do @(posedge clk_i); while (!cfg_ready_o);
      limit_by_reg[r] = vals[r];
      limit_writes++;
    end
    cfg_valid_i <= 1'b0;
  endtask

  function automatic void check_field(string name, int want, int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      faults++;
    end
  endfunction

  // status word checker, compares against the oldest expectation
  always @(posedge clk_i) begin : status_check
    panel_status_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (m_axis_tdata[1:0] < 2'd3) words_in_mode[m_axis_tdata[1:0]]++;
      if (status_due.size() == 0) begin
        $error("status word 0x%02h with no tick outstanding", m_axis_tdata);
        faults++;
      end else begin
        want = status_due.pop_front();
        words_checked++;
        check_field("mode", int'(want.mode), int'(m_axis_tdata[1:0]));
        check_field("tone_enable", int'(want.tone_enable), int'(m_axis_tdata[2]));
        check_field("temp_alarm", int'(want.temp_alarm), int'(m_axis_tdata[3]));
        check_field("unit_fahrenheit", int'(want.unit_fahrenheit), int'(m_axis_tdata[4]));
        check_field("led_a", int'(want.led_a), int'(m_axis_tdata[5]));
        check_field("led_b", int'(want.led_b), int'(m_axis_tdata[6]));
      end
    end
  end

  // receiver: short random stalls, plus a long hold-off whenever one is asked for
  initial begin : receiver
    int unsigned burst;
    int unsigned holds_done;
    burst = 0;
    holds_done = 0;
    forever begin
      @(posedge clk_i);
      if (holds_done < holds_asked) begin
        holds_done++;
        m_axis_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk_i);
      end else if (burst != 0) begin
        burst--;
        m_axis_tready <= 1'b0;
      end else if (rx_idling && $urandom_range(0, 4) == 0) begin
        burst = $urandom_range(0, 6);
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin : watchdog
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $error("timeout after %0d cycles, %0d status words outstanding", cycle_count,
             status_due.size());
      $display("tb: done, errors");
      $finish;
    end
  end

  initial begin : stimulus
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed ticks on the reset limits
    for (int n = 0; n < 22; n++)
      send_tick(DIRECTED[n].item, DIRECTED[n].pinned, DIRECTED[n].status);

    // random phases, each behind a fresh set of limits
    for (int ph = 0; ph < 6; ph++) begin
      wait_drained();
      case (ph)
        0: write_limits(-9'sd128, 9'sd255, -9'sd128, 9'sd255);
        1: write_limits(9'sd255, 9'sd255, 9'sd255, 9'sd255);
        2: write_limits(-9'sd128, -9'sd128, -9'sd128, -9'sd128);
        3: write_limits(C_LOW_RST, C_HIGH_RST, F_LOW_RST, F_HIGH_RST);
        default: write_limits(random_limit(), random_limit(), random_limit(), random_limit());
      endcase
      // a stretch with no idling mid-run, and none at all in the last phase
      tx_idling  = (ph != 2) && (ph != 5);
      rx_idling  = tx_idling;
      touch_odds = (ph % 2 == 0) ? 7 : 23;
      for (int k = 0; k < RANDOM_TICKS; k++) begin
        // receiver holds off long enough to back up the input side
        if (ph == 1 && k == 60) holds_asked++;
        // sender pauses until the pipeline is empty
        if (ph == 3 && k == 90) wait_drained();
        send_tick(random_tick(), 1'b0, UNPINNED);
      end
    end

    wait_drained();
    repeat (8) @(posedge clk_i);
    if (status_due.size() != 0) begin
      $error("%0d status words never arrived", status_due.size());
      faults++;
    end
    $display("tb: %0d ticks, %0d status words checked, %0d limit writes", ticks_sent,
             words_checked, limit_writes);
    $display("tb: words seen disarmed %0d, armed %0d, alarm %0d", words_in_mode[0],
             words_in_mode[1], words_in_mode[2]);
    if (faults == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/apc_pkg.sv
hw/rtl/apc_cfg.sv
hw/rtl/apc_mode.sv
hw/rtl/apc_led.sv
hw/rtl/alarm_panel_controller.sv
tb/tb.sv
